// File: design/tzol_pkg.sv
package tzol_pkg;

   localparam int unsigned CSR_DW     = 11;
   localparam int unsigned SCAN_LANES = 16;
   localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
   localparam int unsigned DIV60_SHIFT = 37;

   typedef enum logic [1:0] {
      CMD_WR_TRANS = 2'd0,
      CMD_WR_TYPE  = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_RSVD     = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_TRANS_COUNT = 1'b0,
      CSR_TYPE_COUNT  = 1'b1
   } csr_index_type;

endpackage

// File: design/tzol_req_if.sv
interface tzol_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [9:0]         entry_index;
   logic signed [63:0] transition_time;
   logic [7:0]         type_ref;
   logic signed [31:0] utc_offset_sec;
   logic               dst_flag;
   logic signed [63:0] query_epoch;

   modport source (
      output valid, cmd, entry_index, transition_time, type_ref, utc_offset_sec,
             dst_flag, query_epoch,
      input  ready
   );
   modport sink (
      input  valid, cmd, entry_index, transition_time, type_ref, utc_offset_sec,
             dst_flag, query_epoch,
      output ready
   );
endinterface

// File: design/tzol_rsp_if.sv
interface tzol_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic signed [26:0] offset_minutes;

   modport source (output valid, status, offset_minutes, input ready);
   modport sink (input valid, status, offset_minutes, output ready);
endinterface

// File: design/tzol_ram.sv
module tzol_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/tzol_div60.sv
module tzol_div60
   import tzol_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] dividend,
   output logic signed [26:0] quotient
);
   logic [31:0] abs_ff, abs_in;
   logic        neg1_ff, neg2_ff;
   logic        v1_ff;
   logic [63:0] prod_ff;
   logic [26:0] mag;

   // x / 60 for x < 2^32 via reciprocal multiply
   assign abs_in = dividend[31] ? (~dividend + 32'd1) : dividend;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         abs_ff  <= abs_in;
         neg1_ff <= dividend[31];
      end
      if (v1_ff) begin
         prod_ff <= 64'(abs_ff) * 64'(DIV60_MAGIC);
         neg2_ff <= neg1_ff;
      end
   end

   assign mag      = prod_ff[63:DIV60_SHIFT];
   assign quotient = neg2_ff ? $signed(~mag + 27'd1) : $signed(mag);
endmodule

// File: design/tz_offset_table_lookup.sv
// Writes: a transaction every cycle while idle.
// Query: a binary search over the n transitions in use, probing the transition RAM
// in S_PROBE and comparing in S_CMP, then, when no transition precedes, a scan for
// the first standard-time type in windows of 16 types.
// An empty type table answers with an error status, skipping the search. One query in flight at a time.
// Reset clears counts and control only; table contents stay, no clearing pass.
module tz_offset_table_lookup
   import tzol_pkg::*;
#(
   parameter int unsigned TRANS_DEPTH = 1024,
   parameter int unsigned TYPE_DEPTH  = 256
) (
   input  logic              clock,
   input  logic              reset,
   tzol_req_if.sink          req_ch,
   tzol_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  csr_index_type     csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);
   localparam int unsigned TAW    = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
   localparam int unsigned CW     = $clog2(TRANS_DEPTH + 1);
   localparam int unsigned YAW    = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
   localparam int unsigned NCHUNK = (TYPE_DEPTH + SCAN_LANES - 1) / SCAN_LANES;
   localparam int unsigned SCAN_W = NCHUNK * SCAN_LANES;
   localparam int unsigned LW     = $clog2(SCAN_LANES);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PROBE = 8'b0000_0010,
      S_CMP   = 8'b0000_0100,
      S_SCAN  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_TDATA = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [10:0]        trans_count_ff;
   logic [8:0]         type_count_ff;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic               found_ff, found_in;
   logic [7:0]         ftype_ff, ftype_in;
   logic [7:0]         typeidx_ff, typeidx_in;
   logic signed [63:0] epoch_ff, epoch_in;
   logic [8:0]         ntypes_ff, ntypes_in;
   logic               err_ff, err_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [8:0]         base_ff, base_in;
   logic [TYPE_DEPTH-1:0] dst_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff;
   logic signed [26:0] rsp_offset_ff;

   logic               accept, rsp_load;
   logic [CW-1:0]      ntrans_now, mid;
   logic [CW:0]        mid_sum;
   logic [8:0]         ntypes_now;
   logic               trans_wr_en, type_wr_en, trans_rd_en, type_rd_en;
   logic [71:0]        trans_rd_data;
   logic [31:0]        type_rd_data;
   logic               le;
   logic               hit, scan_done;
   logic [LW-1:0]      hit_lane;
   logic               div_in_valid;
   logic signed [26:0] div_q;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign ntrans_now = (32'(trans_count_ff) > TRANS_DEPTH) ? CW'(TRANS_DEPTH)
                                                           : CW'(trans_count_ff);
   assign ntypes_now = (32'(type_count_ff) > TYPE_DEPTH) ? 9'(TYPE_DEPTH) : type_count_ff;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid     = mid_sum[CW:1];

   assign trans_wr_en = accept && (cmd_type'(req_ch.cmd) == CMD_WR_TRANS)
                        && (32'(req_ch.entry_index) < TRANS_DEPTH);
   assign type_wr_en  = accept && (cmd_type'(req_ch.cmd) == CMD_WR_TYPE)
                        && (32'(req_ch.entry_index) < TYPE_DEPTH);

   tzol_ram #(.WIDTH(72), .DEPTH(TRANS_DEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_wr_en),
      .wr_addr (TAW'(req_ch.entry_index)),
      .wr_data ({req_ch.type_ref, req_ch.transition_time}),
      .rd_en   (trans_rd_en),
      .rd_addr (TAW'(mid)),
      .rd_data (trans_rd_data)
   );

   tzol_ram #(.WIDTH(32), .DEPTH(TYPE_DEPTH)) u_type_ram (
      .clock   (clock),
      .wr_en   (type_wr_en),
      .wr_addr (YAW'(req_ch.entry_index)),
      .wr_data (req_ch.utc_offset_sec),
      .rd_en   (type_rd_en),
      .rd_addr (YAW'(typeidx_ff)),
      .rd_data (type_rd_data)
   );

   tzol_div60 u_div60 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_in_valid),
      .dividend ($signed(type_rd_data)),
      .quotient (div_q)
   );

   assign le = $signed(trans_rd_data[63:0]) <= epoch_ff;

   // first standard-time type in the current 16-wide window
   always_comb begin
      hit      = 1'b0;
      hit_lane = '0;
      for (int j = SCAN_LANES - 1; j >= 0; j--) begin
         if (!scan_ff[j] && (({1'b0, base_ff} + 10'(j)) < {1'b0, ntypes_ff})) begin
            hit      = 1'b1;
            hit_lane = LW'(j);
         end
      end
   end

   assign scan_done = hit || (({1'b0, base_ff} + 10'(SCAN_LANES)) >= {1'b0, ntypes_ff});
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      ftype_in     = ftype_ff;
      typeidx_in   = typeidx_ff;
      epoch_in     = epoch_ff;
      ntypes_in    = ntypes_ff;
      err_in       = err_ff;
      scan_in      = scan_ff;
      base_in      = base_ff;
      trans_rd_en  = 1'b0;
      type_rd_en   = 1'b0;
      div_in_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (cmd_type'(req_ch.cmd) == CMD_QUERY)) begin
               epoch_in  = req_ch.query_epoch;
               ntypes_in = ntypes_now;
               lo_in     = '0;
               hi_in     = ntrans_now;
               found_in  = 1'b0;
               scan_in   = SCAN_W'(dst_ff);
               base_in   = '0;
               err_in    = (ntypes_now == 9'd0);
               state_in  = (ntypes_now == 9'd0) ? S_OUT : S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               trans_rd_en = 1'b1;
               mid_in      = mid;
               state_in    = S_CMP;
            end else if (found_ff) begin
               typeidx_in = ftype_ff;
               state_in   = S_CHECK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_CMP: begin
            if (le) begin
               found_in = 1'b1;
               ftype_in = trans_rd_data[71:64];
               lo_in    = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_PROBE;
         end
         S_SCAN: begin
            if (scan_done) begin
               typeidx_in = hit ? 8'(base_ff + 9'(hit_lane)) : 8'd0;
               state_in   = S_CHECK;
            end else begin
               scan_in = scan_ff >> SCAN_LANES;
               base_in = base_ff + 9'(SCAN_LANES);
            end
         end
         S_CHECK: begin
            if ({1'b0, typeidx_ff} >= ntypes_ff) begin
               err_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               type_rd_en = 1'b1;
               state_in   = S_TDATA;
            end
         end
         S_TDATA: begin
            div_in_valid = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         trans_count_ff <= '0;
         type_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TRANS_COUNT: trans_count_ff <= csr_wdata[10:0];
               CSR_TYPE_COUNT:  type_count_ff  <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      found_ff   <= found_in;
      ftype_ff   <= ftype_in;
      typeidx_ff <= typeidx_in;
      epoch_ff   <= epoch_in;
      ntypes_ff  <= ntypes_in;
      err_ff     <= err_in;
      scan_ff    <= scan_in;
      base_ff    <= base_in;
      if (type_wr_en) begin
         dst_ff[YAW'(req_ch.entry_index)] <= req_ch.dst_flag;
      end
      if (rsp_load) begin
         rsp_status_ff <= err_ff;
         rsp_offset_ff <= err_ff ? 27'sd0 : div_q;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.offset_minutes = rsp_offset_ff;
endmodule
